>>> src/hxy_pkg.sv
// shared constants and types for the hilbert index pipeline
`timescale 1ns / 1ps
package hxy_pkg;

   localparam int GRID_SIZE_DEF = 1024;
   localparam int COORD_W       = 10;
   localparam int INDEX_W       = 20;
   localparam int MODE_W        = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDENT    = 3'd0,
      MODE_ROT_CW   = 3'd1,
      MODE_ROT_CCW  = 3'd2,
      MODE_ROT_180  = 3'd3,
      MODE_SHIFT_LL = 3'd4,
      MODE_SHIFT_HL = 3'd5,
      MODE_SHIFT_LH = 3'd6,
      MODE_SHIFT_HH = 3'd7
   } mode_type;

endpackage

>>> src/hxy_transform.sv
// input stage: grid check, point transform and range check, registered
`timescale 1ns / 1ps
module hxy_transform #(
   parameter int GRID_SIZE = hxy_pkg::GRID_SIZE_DEF,
   parameter int CW        = $clog2(GRID_SIZE)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hxy_pkg::mode_type              mode,
   input  logic                           up_valid,
   input  logic [hxy_pkg::COORD_W-1:0]    up_x,
   input  logic [hxy_pkg::COORD_W-1:0]    up_y,
   output logic                           dn_valid,
   output logic [CW-1:0]                  dn_x,
   output logic [CW-1:0]                  dn_y
);

   localparam int XW = ((CW > hxy_pkg::COORD_W) ? CW : hxy_pkg::COORD_W) + 1;
   localparam logic [XW-1:0] N_EXT = XW'(GRID_SIZE);
   localparam logic [CW-1:0] TOP   = CW'(GRID_SIZE - 1);

   logic          in_grid;
   logic          keep;
   logic [CW-1:0] xc;
   logic [CW-1:0] yc;
   logic [CW-1:0] tx;
   logic [CW-1:0] ty;

   logic          valid_ff;
   logic          valid_in;
   logic [CW-1:0] x_ff;
   logic [CW-1:0] x_in;
   logic [CW-1:0] y_ff;
   logic [CW-1:0] y_in;

   always_comb begin
      in_grid = (XW'(up_x) < N_EXT) && (XW'(up_y) < N_EXT);
      xc      = CW'(up_x);
      yc      = CW'(up_y);
      keep    = 1'b1;
      tx      = xc;
      ty      = yc;
      case (mode)
         hxy_pkg::MODE_IDENT: begin
            tx = xc;
            ty = yc;
         end
         hxy_pkg::MODE_ROT_CW: begin
            tx = TOP - yc;
            ty = xc;
         end
         hxy_pkg::MODE_ROT_CCW: begin
            tx = yc;
            ty = TOP - xc;
         end
         hxy_pkg::MODE_ROT_180: begin
            tx = TOP - xc;
            ty = TOP - yc;
         end
         hxy_pkg::MODE_SHIFT_LL: begin
            keep = (xc != '0) && (yc != '0);
            tx   = xc - CW'(1);
            ty   = yc - CW'(1);
         end
         hxy_pkg::MODE_SHIFT_HL: begin
            keep = (xc != TOP) && (yc != '0);
            tx   = xc + CW'(1);
            ty   = yc - CW'(1);
         end
         hxy_pkg::MODE_SHIFT_LH: begin
            keep = (xc != '0) && (yc != TOP);
            tx   = xc - CW'(1);
            ty   = yc + CW'(1);
         end
         hxy_pkg::MODE_SHIFT_HH: begin
            keep = (xc != TOP) && (yc != TOP);
            tx   = xc + CW'(1);
            ty   = yc + CW'(1);
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      valid_in = up_valid && in_grid && keep;
      x_in     = tx;
      y_in     = ty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;

   // points off the grid never reach the levels
   a_off_grid_dropped: assert property (@(posedge clock) disable iff (reset)
      (up_valid && !in_grid) |=> !dn_valid)
      else $error("off-grid point passed the input stage");

   // identity keeps the coordinates
   a_ident_keeps: assert property (@(posedge clock) disable iff (reset)
      (up_valid && in_grid && mode == hxy_pkg::MODE_IDENT)
         |=> (dn_valid && dn_x == $past(xc) && dn_y == $past(yc)))
      else $error("identity transform altered the point");

endmodule

>>> src/hxy_level.sv
// one curve level: quadrant digit, index accumulate, reflect and swap
`timescale 1ns / 1ps
module hxy_level #(
   parameter int CW    = 10,
   parameter int STEP  = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   input  logic [CW-1:0]                 up_x,
   input  logic [CW-1:0]                 up_y,
   input  logic [hxy_pkg::INDEX_W-1:0]   up_index,
   output logic                          dn_valid,
   output logic [CW-1:0]                 dn_x,
   output logic [CW-1:0]                 dn_y,
   output logic [hxy_pkg::INDEX_W-1:0]   dn_index
);

   localparam logic [CW-1:0]                S_V  = CW'(STEP);
   localparam logic [CW-1:0]                S_M1 = CW'(STEP - 1);
   localparam longint                       SQ_L = longint'(STEP) * longint'(STEP);
   localparam logic [hxy_pkg::INDEX_W-1:0]  SQ   = hxy_pkg::INDEX_W'(SQ_L);
   localparam logic [hxy_pkg::INDEX_W-1:0]  SQ2  = hxy_pkg::INDEX_W'(SQ_L * 2);

   logic                         rx;
   logic                         ry;
   logic [1:0]                   digit;
   logic [CW-1:0]                fx;
   logic [CW-1:0]                fy;

   logic                         valid_ff;
   logic                         valid_in;
   logic [CW-1:0]                x_ff;
   logic [CW-1:0]                x_in;
   logic [CW-1:0]                y_ff;
   logic [CW-1:0]                y_in;
   logic [hxy_pkg::INDEX_W-1:0]  index_ff;
   logic [hxy_pkg::INDEX_W-1:0]  index_in;

   always_comb begin
      rx    = |(up_x & S_V);
      ry    = |(up_y & S_V);
      // digit is (3*rx) xor ry
      digit = {rx, rx ^ ry};
      index_in = up_index + (digit[0] ? SQ : '0) + (digit[1] ? SQ2 : '0);
      fx = rx ? (S_M1 - up_x) : up_x;
      fy = rx ? (S_M1 - up_y) : up_y;
      if (!ry) begin
         x_in = fy;
         y_in = fx;
      end else begin
         x_in = up_x;
         y_in = up_y;
      end
      valid_in = up_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      index_ff <= index_in;
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_index = index_ff;

   a_valid_moves: assert property (@(posedge clock) disable iff (reset)
      up_valid |=> dn_valid)
      else $error("beat lost in curve level");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !up_valid |=> !dn_valid)
      else $error("beat invented in curve level");

endmodule

>>> src/hilbert_xy_to_index_transformed.sv
// top level: mode register, input stage and one pipeline stage per curve level
// throughput: one point per cycle; busy stays low, one register stage per level
// points that fall off the grid are dropped in the input stage and give no beat
// reset: synchronous, clears the mode to identity and all stage valid bits
`timescale 1ns / 1ps
module hilbert_xy_to_index_transformed #(
   parameter int GRID_SIZE = hxy_pkg::GRID_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [hxy_pkg::COORD_W-1:0]    req_coord_x,
   input  logic [hxy_pkg::COORD_W-1:0]    req_coord_y,
   output logic                           rsp_valid,
   output logic [hxy_pkg::INDEX_W-1:0]    rsp_curve_index,
   input  logic                           csr_we,
   input  logic [hxy_pkg::MODE_W-1:0]     csr_wdata
);

   localparam int CW     = $clog2(GRID_SIZE);
   localparam int LEVELS = $clog2(GRID_SIZE + 1) - 1;

   hxy_pkg::mode_type mode_ff;

   logic                         v_chain [0:LEVELS];
   logic [CW-1:0]                x_chain [0:LEVELS];
   logic [CW-1:0]                y_chain [0:LEVELS];
   logic [hxy_pkg::INDEX_W-1:0]  d_chain [0:LEVELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= hxy_pkg::MODE_IDENT;
      end else if (csr_we) begin
         mode_ff <= hxy_pkg::mode_type'(csr_wdata);
      end
   end

   assign busy = 1'b0;

   hxy_transform #(
      .GRID_SIZE (GRID_SIZE),
      .CW        (CW)
   ) u_transform (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_ff),
      .up_valid (start && !busy),
      .up_x     (req_coord_x),
      .up_y     (req_coord_y),
      .dn_valid (v_chain[0]),
      .dn_x     (x_chain[0]),
      .dn_y     (y_chain[0])
   );

   assign d_chain[0] = '0;

   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      hxy_level #(
         .CW   (CW),
         .STEP (GRID_SIZE >> (k + 1))
      ) u_level (
         .clock    (clock),
         .reset    (reset),
         .up_valid (v_chain[k]),
         .up_x     (x_chain[k]),
         .up_y     (y_chain[k]),
         .up_index (d_chain[k]),
         .dn_valid (v_chain[k+1]),
         .dn_x     (x_chain[k+1]),
         .dn_y     (y_chain[k+1]),
         .dn_index (d_chain[k+1])
      );
   end

   assign rsp_valid       = v_chain[LEVELS];
   assign rsp_curve_index = d_chain[LEVELS];

   a_mode_holds: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> $stable(mode_ff))
      else $error("mode changed without a write");

endmodule

>>> dv/hilbert_xy_to_index_transformed_tb.sv
// self-checking testbench for the transformed-point hilbert index block
`timescale 1ns / 1ps
module hilbert_xy_to_index_transformed_tb;
   import hxy_pkg::*;

   localparam int GRID      = 1024;
   localparam int LATENCY   = 12;
   localparam int PHASES    = 16;
   localparam int PER_PHASE = 116;
   localparam int LIMIT     = 400000;

   localparam logic [COORD_W-1:0] C_TOP    = COORD_W'(GRID - 1);
   localparam logic [COORD_W-1:0] C_NEAR   = COORD_W'(GRID - 2);
   localparam logic [COORD_W-1:0] C_MID    = COORD_W'(GRID / 2);
   localparam logic [COORD_W-1:0] C_MID_LO = COORD_W'(GRID / 2 - 1);

   class curve_scoreboard;
      mode_type           mode;
      logic [INDEX_W-1:0] pending_index[$];
      int                 errors;

      function new();
         mode   = MODE_IDENT;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // hilbert position of (x, y), wrapping like 64-bit unsigned math
      function logic [INDEX_W-1:0] curve_position(input bit [63:0] x, input bit [63:0] y);
         bit [63:0] s;
         bit [63:0] d;
         bit [63:0] t;
         bit [63:0] rx;
         bit [63:0] ry;
         d = 0;
         for (s = GRID / 2; s > 0; s = s / 2) begin
            rx = ((x & s) != 0) ? 1 : 0;
            ry = ((y & s) != 0) ? 1 : 0;
            d  = d + s * s * ((3 * rx) ^ ry);
            if (ry == 0) begin
               if (rx == 1) begin
                  x = s - 1 - x;
                  y = s - 1 - y;
               end
               t = x;
               x = y;
               y = t;
            end
         end
         return d[INDEX_W-1:0];
      endfunction

      // transform the point; returns 0 when it falls off the grid
      function bit transformed_index(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                     output logic [INDEX_W-1:0] idx);
         bit [63:0] top;
         bit [63:0] tx;
         bit [63:0] ty;
         top = GRID - 1;
         idx = '0;
         case (mode)
            MODE_IDENT: begin
               tx = x;
               ty = y;
            end
            MODE_ROT_CW: begin
               tx = top - y;
               ty = x;
            end
            MODE_ROT_CCW: begin
               tx = y;
               ty = top - x;
            end
            MODE_ROT_180: begin
               tx = top - x;
               ty = top - y;
            end
            MODE_SHIFT_LL: begin
               if (!(x > 0 && y > 0)) return 0;
               tx = x - 1;
               ty = y - 1;
            end
            MODE_SHIFT_HL: begin
               if (!(x < top && y > 0)) return 0;
               tx = x + 1;
               ty = y - 1;
            end
            MODE_SHIFT_LH: begin
               if (!(x > 0 && y < top)) return 0;
               tx = x - 1;
               ty = y + 1;
            end
            default: begin
               if (!(x < top && y < top)) return 0;
               tx = x + 1;
               ty = y + 1;
            end
         endcase
         idx = curve_position(tx, ty);
         return 1;
      endfunction

      function void note_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
         logic [INDEX_W-1:0] idx;
         if (transformed_index(x, y, idx))
            pending_index.push_back(idx);
      endfunction

      task check_index(input logic [INDEX_W-1:0] got);
         logic [INDEX_W-1:0] want;
         if (pending_index.size() == 0) begin
            report($sformatf("unexpected beat, curve_index %0d", got));
         end else begin
            want = pending_index.pop_front();
            if (got !== want)
               report($sformatf("curve_index got %0d want %0d", got, want));
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [COORD_W-1:0] req_coord_x;
   logic [COORD_W-1:0] req_coord_y;
   logic               rsp_valid;
   logic [INDEX_W-1:0] rsp_curve_index;
   logic               csr_we;
   logic [MODE_W-1:0]  csr_wdata;

   curve_scoreboard sb = new();
   int              cycles = 0;

   hilbert_xy_to_index_transformed #(.GRID_SIZE(GRID)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .rsp_valid       (rsp_valid),
      .rsp_curve_index (rsp_curve_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("hilbert_xy_to_index_transformed_tb: done, errors");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid)
            sb.check_index(rsp_curve_index);
         if (start && !busy)
            sb.note_point(req_coord_x, req_coord_y);
      end
   end

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start       <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending_index.size() != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= m;
      sb.mode = m;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly uniform, with some weight on the grid border
   function automatic logic [COORD_W-1:0] pick_coord();
      logic [COORD_W-1:0] border[4] = '{0, 1, C_NEAR, C_TOP};
      if ($urandom_range(7) == 0)
         return border[2'($urandom_range(3))];
      return COORD_W'($urandom_range(GRID - 1));
   endfunction

   initial begin
      mode_type order[8] = '{MODE_IDENT, MODE_SHIFT_HH, MODE_ROT_180, MODE_SHIFT_LL,
                             MODE_ROT_CW, MODE_SHIFT_HL, MODE_ROT_CCW, MODE_SHIFT_LH};
      mode_type m;
      int       idle_pct;

      reset       = 1'b1;
      start       = 1'b0;
      req_coord_x = '0;
      req_coord_y = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: corners, center and the edges where shifts drop the point
      write_mode(MODE_IDENT);
      send_point(0, 0, 0);
      send_point(C_TOP, C_TOP, 0);
      send_point(0, C_TOP, 0);
      send_point(C_TOP, 0, 0);
      send_point(C_MID, C_MID_LO, 0);
      write_mode(MODE_ROT_CW);
      send_point(0, C_TOP, 0);
      send_point(C_TOP, 0, 0);
      write_mode(MODE_ROT_CCW);
      send_point(0, 0, 0);
      send_point(C_TOP, C_TOP, 0);
      write_mode(MODE_ROT_180);
      send_point(0, 0, 0);
      send_point(C_TOP, C_TOP, 0);
      write_mode(MODE_SHIFT_LL);
      send_point(0, 5, 0);
      send_point(5, 0, 0);
      send_point(1, 1, 0);
      write_mode(MODE_SHIFT_HL);
      send_point(C_TOP, 3, 0);
      send_point(3, 0, 0);
      send_point(C_NEAR, 1, 0);
      write_mode(MODE_SHIFT_LH);
      send_point(0, 3, 0);
      send_point(3, C_TOP, 0);
      send_point(1, C_NEAR, 0);
      write_mode(MODE_SHIFT_HH);
      send_point(C_TOP, 5, 0);
      send_point(5, C_TOP, 0);
      send_point(C_NEAR, C_NEAR, 0);

      // random phases: every mode in turn, then random modes
      for (int p = 0; p < PHASES; p++) begin
         m = (p < 8) ? order[p] : mode_type'(MODE_W'($urandom_range(7)));
         case (p % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 61;
            default: idle_pct = 25;
         endcase
         write_mode(m);
         for (int i = 0; i < PER_PHASE; i++)
            send_point(pick_coord(), pick_coord(), idle_pct);
      end

      drain();
      repeat (LATENCY) @(negedge clock);
      if (sb.pending_index.size() != 0)
         sb.report($sformatf("%0d beats never arrived", sb.pending_index.size()));
      if (sb.errors == 0)
         $display("hilbert_xy_to_index_transformed_tb: done, clean");
      else
         $display("hilbert_xy_to_index_transformed_tb: done, errors");
      $finish;
   end

endmodule
